/* sv/sbfd_pkg.sv */
// shared types and constants for the six-bit frame decoder
package sbfd_pkg;

  localparam logic [7:0] FRAME_OPEN      = 8'h09;
  localparam logic [7:0] FRAME_CLOSE     = 8'h0a;
  localparam logic [7:0] SYMBOL_BASE     = 8'h40;
  localparam logic [7:0] MAX_OUT_DEFAULT = 8'd10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STRAY_W = 16;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_STRAY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    logic                 in_frame;
    logic [2:0]           shift_pos;
    logic [15:0]          accum;
    logic [7:0]           last_group;
    logic [7:0]           bad_count;
    logic [7:0]           out_count;
    logic                 truncated;
    logic [STRAY_W-1:0]   stray_count;
  } dec_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data_byte;
    status_t              frame_status;
    logic [7:0]           bad_symbols;
    logic [7:0]           byte_count;
    logic [STRAY_W-1:0]   stray_total;
  } dec_result_t;

endpackage

/* sv/sbfd_step.sv */
// combinational next-state and result logic for one received byte
module sbfd_step
  import sbfd_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  max_out_i,
  output dec_state_t  state_o,
  output logic        has_result_o,
  output dec_result_t result_o
);

  logic [7:0]  group;
  logic [15:0] shifted;
  logic [15:0] merged;
  logic [3:0]  pos_sum;
  logic [7:0]  cnt_inc;

  // group to merge: new symbol or the previous one for a bad symbol
  assign group = (rx_byte_i >= SYMBOL_BASE) ? 8'(rx_byte_i - SYMBOL_BASE)
                                            : state_i.last_group;

  // shift is 10 minus the position; position is always even
  always_comb begin
    case (state_i.shift_pos[2:1])
      2'd0:    shifted = {group[5:0], 10'd0};
      2'd1:    shifted = {group, 8'd0};
      2'd2:    shifted = {2'd0, group, 6'd0};
      default: shifted = {4'd0, group, 4'd0};
    endcase
  end

  assign merged  = state_i.accum | shifted;
  assign pos_sum = {1'b0, state_i.shift_pos} + 4'd6;
  assign cnt_inc = (state_i.out_count != 8'hff) ? 8'(state_i.out_count + 8'd1)
                                               : state_i.out_count;

  always_comb begin
    state_o                   = state_i;
    has_result_o              = 1'b0;
    result_o                  = '0;
    result_o.kind             = KIND_DATA;
    result_o.frame_status     = STATUS_OK;
    result_o.stray_total      = state_i.stray_count;

    if (!state_i.in_frame) begin
      if (rx_byte_i == FRAME_OPEN) begin
        state_o.in_frame   = 1'b1;
        state_o.shift_pos  = '0;
        state_o.accum      = '0;
        state_o.last_group = '0;
        state_o.bad_count  = '0;
        state_o.out_count  = '0;
        state_o.truncated  = 1'b0;
      end else begin
        state_o.stray_count  = STRAY_W'(state_i.stray_count + 1'b1);
        has_result_o         = 1'b1;
        result_o.kind        = KIND_STRAY;
        result_o.stray_total = STRAY_W'(state_i.stray_count + 1'b1);
      end
    end else if (rx_byte_i == FRAME_CLOSE) begin
      state_o.in_frame     = 1'b0;
      has_result_o         = 1'b1;
      result_o.kind        = KIND_END;
      result_o.bad_symbols = state_i.bad_count;
      result_o.byte_count  = state_i.out_count;
      if (state_i.truncated) begin
        result_o.frame_status = STATUS_TRUNC;
      end else if (state_i.bad_count != 8'd0) begin
        result_o.frame_status = STATUS_BAD;
      end
    end else if (!state_i.truncated) begin
      state_o.last_group = group;
      if (rx_byte_i < SYMBOL_BASE && state_i.bad_count != 8'hff) begin
        state_o.bad_count = 8'(state_i.bad_count + 8'd1);
      end
      if (pos_sum[3]) begin
        // eight bits complete: emit the top byte
        state_o.shift_pos   = pos_sum[2:0];
        state_o.accum       = {merged[7:0], 8'd0};
        state_o.out_count   = cnt_inc;
        state_o.truncated   = (cnt_inc >= max_out_i);
        has_result_o        = 1'b1;
        result_o.data_byte  = merged[15:8];
      end else begin
        state_o.shift_pos = pos_sum[2:0];
        state_o.accum     = merged;
      end
    end
  end

endmodule

/* sv/six_bit_frame_decoder.sv */
// six-bit frame decoder top level: input register, decode step, result register
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid / in_tready  in_tdata: rx_byte
//  out_     master     out_tvalid/out_tready  out_tdata: decoded fields, out_tuser: kind
//  cfg_     write      cfg_wr_en              cfg_wr_data: max_out_bytes
//
// one byte per cycle sustained while the result register is not stalled
// the input register feeds the decode step, which writes state and the result register
// bytes that give no result (frame open, symbols that complete no byte, bytes after truncation) leave only state behind
// a stalled result register holds the input register, which then holds in_tready low
// rst_n is synchronous, active low; the limit resets to ten
module six_bit_frame_decoder
  import sbfd_pkg::*;
#(
  parameter logic [7:0] MAX_OUT_RESET = MAX_OUT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // max_out_bytes
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [7:0] data_byte, [9:8] frame_status,
                                     // [17:10] bad_symbols, [25:18] byte_count,
                                     // [41:26] stray_total, [47:42] zero
  output logic [1:0]  out_tuser      // [1:0] kind
);

  logic [7:0]  max_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;

  // decoder state
  dec_state_t  st_r, st_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  dec_result_t out_res_r;

  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  logic        step_has_res;
  dec_result_t step_res;

  sbfd_step u_step (
    .state_i      (st_r),
    .rx_byte_i    (s1_byte_r),
    .max_out_i    (max_r),
    .state_o      (st_nxt),
    .has_result_o (step_has_res),
    .result_o     (step_res)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? step_has_res : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_OUT_RESET;
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_fire && step_has_res) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.stray_total, out_res_r.byte_count,
                       out_res_r.bad_symbols, out_res_r.frame_status,
                       out_res_r.data_byte};

  // bit position moves in steps of six modulo eight and restarts at zero, so it stays even
  a_even_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.shift_pos[0] == 1'b0)
    else $error("odd shift position");

  // a truncated frame has emitted at least one byte
  a_trunc_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.in_frame && st_r.truncated |-> st_r.out_count != 8'd0)
    else $error("truncated with no bytes emitted");

  // stray count moves only by one
  a_stray_step: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stray_count != $past(st_r.stray_count) |->
      st_r.stray_count == STRAY_W'($past(st_r.stray_count) + 1'b1))
    else $error("stray count jumped");

  // a held input byte is not dropped while the result slot is busy
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input byte lost under stall");

endmodule
